// ----- hdl/cfpu_pkg.sv -----
// ----------------------------------------------------------------------------
// cfpu_pkg
// Types and constants shared by the constant fold and propagate unit.
// ----------------------------------------------------------------------------
package cfpu_pkg;

   localparam int unsigned IdWidth = 10;
   localparam int unsigned DataWidth = 64;
   localparam int unsigned ByteBits = 8;

   typedef enum logic [4:0] {
      OP_ADD     = 5'd0,
      OP_SUB     = 5'd1,
      OP_MUL     = 5'd2,
      OP_DIV     = 5'd3,
      OP_MOD     = 5'd4,
      OP_AND     = 5'd5,
      OP_OR      = 5'd6,
      OP_XOR     = 5'd7,
      OP_SHL     = 5'd8,
      OP_SHR     = 5'd9,
      OP_EQ      = 5'd10,
      OP_NE      = 5'd11,
      OP_LT      = 5'd12,
      OP_LE      = 5'd13,
      OP_GT      = 5'd14,
      OP_GE      = 5'd15,
      OP_NEG     = 5'd16,
      OP_NOT     = 5'd17,
      OP_LOGNOT  = 5'd18,
      OP_CAST    = 5'd19,
      OP_ICONST  = 5'd20,
      OP_BARRIER = 5'd21,
      OP_OTHER   = 5'd22
   } opcode_type;

   localparam logic [1:0] CAST_B1 = 2'd0;
   localparam logic [1:0] CAST_B2 = 2'd1;
   localparam logic [1:0] CAST_B4 = 2'd2;
   localparam logic [1:0] CAST_B8 = 2'd3;

   typedef struct packed {
      logic [4:0]           opcode;
      logic [IdWidth-1:0]   dest_id;
      logic [IdWidth-1:0]   first_src_id;
      logic [IdWidth-1:0]   second_src_id;
      logic                 has_dest;
      logic                 has_first_src;
      logic                 has_second_src;
      logic signed [DataWidth-1:0] immediate;
      logic [1:0]           cast_bytes_code;
      logic                 cast_to_unsigned;
      logic                 cast_to_float;
   } req_type;

   typedef struct packed {
      logic                 folded;
      logic signed [DataWidth-1:0] folded_value;
      logic                 operands_swapped;
      logic [4:0]           new_opcode;
      logic                 changed;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_READ,
      ST_EVAL,
      ST_MUL,
      ST_DIV,
      ST_DIVFIX,
      ST_WRITE,
      ST_OUT
   } state_type;

   // evaluation request from sequencer to the arithmetic unit
   typedef struct packed {
      logic       start;
      logic [4:0] op;
   } alu_ctl_type;

   typedef struct packed {
      logic done;
      logic ok;
   } alu_sts_type;

endpackage

// ----- hdl/constant_fold_propagate_unit.sv -----
// ----------------------------------------------------------------------------
// constant_fold_propagate_unit
// Folds constant IR instructions and canonicalises operand order.
// ----------------------------------------------------------------------------
// One item at a time. The steps, from acceptance to the next acceptance:
// - An integer constant: accept, write.
// - An item with no destination or an unknown operand: accept, table read, write.
// - An item with known operands: accept, table read, start, evaluate, write.
// - A multiply also steps through its 16-bit partial products.
// - A divide or modulo also runs the bit-serial divider and its sign fix-up,
//   unless the divisor is zero.
// The result is valid on the cycle after the write. A stalled result holds
// the following item in the write state.
// A barrier clears the flag memory one entry a cycle, and no item is accepted
// while it runs. The same sweep runs after reset and produces no item. Values
// live in a second memory that is never cleared: an entry is only used while
// its flag is set.
module constant_fold_propagate_unit #(
   parameter int unsigned NUM_VALUES = 1024
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  cfpu_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output cfpu_pkg::rsp_type rsp_data
);

   localparam int unsigned AW = (NUM_VALUES > 1) ? $clog2(NUM_VALUES) : 1;

   cfpu_pkg::state_type st_ff, st_in;

   logic                  flag_mem [NUM_VALUES];
   logic [63:0]           val_mem  [NUM_VALUES];

   cfpu_pkg::req_type     req_ff, req_in;
   logic [AW:0]           clr_ff, clr_in;
   logic                  f1_ff, f2_ff;
   logic [63:0]           v1_ff, v2_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   cfpu_pkg::rsp_type     rsp_ff, rsp_in;
   logic                  fold_ff, fold_in;
   logic [63:0]           fval_ff, fval_in;
   logic                  boot_ff;

   logic                  in1, in2, ind;
   logic                  k1, k2;
   logic                  try2, try1;
   logic                  flag_we, flag_wd;
   logic [AW-1:0]         flag_wa;
   logic                  val_we;
   cfpu_pkg::alu_ctl_type alu_ctl;
   cfpu_pkg::alu_sts_type alu_sts;
   logic [63:0]           alu_res;
   logic                  swap;
   logic [4:0]            mirror_op;

   assign in1 = 32'(req_ff.first_src_id)  < NUM_VALUES;
   assign in2 = 32'(req_ff.second_src_id) < NUM_VALUES;
   assign ind = 32'(req_ff.dest_id)       < NUM_VALUES;
   assign k1  = req_ff.has_first_src  && in1 && f1_ff;
   assign k2  = req_ff.has_second_src && in2 && f2_ff;
   assign try2 = req_ff.has_dest && k1 && k2;
   assign try1 = req_ff.has_dest && k1 && !req_ff.has_second_src;

   always_comb begin
      swap      = 1'b0;
      mirror_op = req_ff.opcode;
      if (k1 && req_ff.has_second_src && !k2) begin
         unique case (req_ff.opcode)
            cfpu_pkg::OP_ADD, cfpu_pkg::OP_MUL, cfpu_pkg::OP_AND,
            cfpu_pkg::OP_OR, cfpu_pkg::OP_XOR, cfpu_pkg::OP_EQ,
            cfpu_pkg::OP_NE: swap = 1'b1;
            cfpu_pkg::OP_LT: begin swap = 1'b1; mirror_op = cfpu_pkg::OP_GT; end
            cfpu_pkg::OP_GT: begin swap = 1'b1; mirror_op = cfpu_pkg::OP_LT; end
            cfpu_pkg::OP_LE: begin swap = 1'b1; mirror_op = cfpu_pkg::OP_GE; end
            cfpu_pkg::OP_GE: begin swap = 1'b1; mirror_op = cfpu_pkg::OP_LE; end
            default: ;
         endcase
      end
   end

   // next state
   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         cfpu_pkg::ST_IDLE:
            if (req_valid) begin
               if (req_data.opcode == cfpu_pkg::OP_BARRIER) st_in = cfpu_pkg::ST_CLEAR;
               else if (req_data.opcode == cfpu_pkg::OP_ICONST) st_in = cfpu_pkg::ST_WRITE;
               else st_in = cfpu_pkg::ST_READ;
            end
         cfpu_pkg::ST_CLEAR:
            if (clr_ff == (AW+1)'(NUM_VALUES - 1))
               st_in = boot_ff ? cfpu_pkg::ST_IDLE : cfpu_pkg::ST_WRITE;
         cfpu_pkg::ST_READ:
            st_in = (try2 || try1) ? cfpu_pkg::ST_EVAL : cfpu_pkg::ST_WRITE;
         cfpu_pkg::ST_EVAL:  st_in = cfpu_pkg::ST_DIV;
         cfpu_pkg::ST_DIV:   if (alu_sts.done) st_in = cfpu_pkg::ST_WRITE;
         cfpu_pkg::ST_WRITE: if (!rsp_valid_ff || !rsp_stall) st_in = cfpu_pkg::ST_IDLE;
         default:            st_in = cfpu_pkg::ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_in       = req_ff;
      clr_in       = clr_ff;
      fold_in      = fold_ff;
      fval_in      = fval_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      req_stall    = (st_ff != cfpu_pkg::ST_IDLE);
      alu_ctl.start = 1'b0;
      alu_ctl.op    = req_ff.opcode;
      flag_we = 1'b0;
      flag_wd = 1'b0;
      flag_wa = AW'(req_ff.dest_id);
      val_we  = 1'b0;
      unique case (st_ff)
         cfpu_pkg::ST_IDLE: begin
            req_in  = req_data;
            clr_in  = '0;
            fold_in = 1'b0;
            fval_in = 64'd0;
         end
         cfpu_pkg::ST_CLEAR: begin
            flag_we = 1'b1;
            flag_wa = clr_ff[AW-1:0];
            clr_in  = clr_ff + (AW+1)'(1);
         end
         cfpu_pkg::ST_READ: ;
         cfpu_pkg::ST_EVAL: alu_ctl.start = 1'b1;
         cfpu_pkg::ST_DIV:
            if (alu_sts.done) begin
               fold_in = alu_sts.ok;
               fval_in = alu_sts.ok ? alu_res : 64'd0;
            end
         cfpu_pkg::ST_WRITE:
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               if (req_ff.opcode == cfpu_pkg::OP_ICONST) begin
                  flag_we = req_ff.has_dest && ind;
                  flag_wd = 1'b1;
                  val_we  = flag_we;
                  rsp_in  = '{1'b0, 64'd0, 1'b0, req_ff.opcode, 1'b0};
               end else if (req_ff.opcode == cfpu_pkg::OP_BARRIER) begin
                  rsp_in  = '{1'b0, 64'd0, 1'b0, req_ff.opcode, 1'b0};
               end else if (fold_ff) begin
                  flag_we = ind;
                  flag_wd = 1'b1;
                  val_we  = ind;
                  rsp_in  = '{1'b1, fval_ff, 1'b0, cfpu_pkg::OP_ICONST, 1'b1};
               end else begin
                  rsp_in  = '{1'b0, 64'd0, swap, mirror_op, swap};
               end
            end
         default: ;
      endcase
   end

   // known flags and values; read with the ids of the item being accepted
   always_ff @(posedge clock) begin
      if (flag_we) flag_mem[flag_wa] <= flag_wd;
      if (val_we)  val_mem[AW'(req_ff.dest_id)]
                     <= (req_ff.opcode == cfpu_pkg::OP_ICONST) ? req_ff.immediate : fval_ff;
      f1_ff <= flag_mem[AW'(req_in.first_src_id)];
      f2_ff <= flag_mem[AW'(req_in.second_src_id)];
      v1_ff <= val_mem[AW'(req_in.first_src_id)];
      v2_ff <= val_mem[AW'(req_in.second_src_id)];
   end

   cfpu_alu u_alu (
      .clock            (clock),
      .reset            (reset),
      .ctl              (alu_ctl),
      .a                (v1_ff),
      .b                (v2_ff),
      .unary            (!req_ff.has_second_src),
      .cast_bytes_code  (req_ff.cast_bytes_code),
      .cast_to_unsigned (req_ff.cast_to_unsigned),
      .cast_to_float    (req_ff.cast_to_float),
      .sts              (alu_sts),
      .result           (alu_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= cfpu_pkg::ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         req_ff.opcode <= cfpu_pkg::OP_BARRIER;
      end else begin
         st_ff        <= st_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         req_ff       <= req_in;
      end
      rsp_ff  <= rsp_in;
      fold_ff <= fold_in;
      fval_ff <= fval_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // reset sweep must not produce an item: first pass has no accepted barrier
   always_ff @(posedge clock) begin
      if (reset) boot_ff <= 1'b1;
      else if (st_ff == cfpu_pkg::ST_CLEAR && st_in != cfpu_pkg::ST_CLEAR) boot_ff <= 1'b0;
   end

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (st_ff != cfpu_pkg::ST_IDLE) |-> req_stall)
      else $error("item accepted while busy");
   a_fold_opcode: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.folded) |-> (rsp_data.new_opcode == cfpu_pkg::OP_ICONST))
      else $error("folded item without iconst opcode");
   a_changed: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.changed == (rsp_data.folded || rsp_data.operands_swapped)))
      else $error("changed flag inconsistent");
   a_boot: assert property (@(posedge clock) disable iff (reset)
      boot_ff |-> !rsp_valid)
      else $error("item produced by reset sweep");

endmodule

// ----- hdl/cfpu_alu.sv -----
// ----------------------------------------------------------------------------
// cfpu_alu
// Multi-cycle evaluator: multiply in 16x64 partial products, divide one bit
// per cycle, everything else combinationally into the result register.
// ----------------------------------------------------------------------------
module cfpu_alu (
   input  logic                   clock,
   input  logic                   reset,
   input  cfpu_pkg::alu_ctl_type  ctl,
   input  logic [63:0]            a,
   input  logic [63:0]            b,
   input  logic                   unary,
   input  logic [1:0]             cast_bytes_code,
   input  logic                   cast_to_unsigned,
   input  logic                   cast_to_float,
   output cfpu_pkg::alu_sts_type  sts,
   output logic [63:0]            result
);

   typedef enum logic [1:0] {A_IDLE, A_MUL, A_DIV, A_FIX} astate_type;

   astate_type    st_ff, st_in;
   logic [63:0]   acc_ff, acc_in;
   logic [63:0]   rem_ff, rem_in;
   logic [63:0]   quo_ff, quo_in;
   logic [63:0]   dvs_ff, dvs_in;
   logic [6:0]    cnt_ff, cnt_in;
   logic [4:0]    op_ff, op_in;
   logic          neg_q_ff, neg_q_in;
   logic          neg_r_ff, neg_r_in;
   logic [63:0]   res_ff, res_in;
   logic          done_ff, done_in;
   logic          ok_ff, ok_in;

   logic [63:0]   comb_r;
   logic          comb_ok;
   logic          slt_ab, slt_ba;
   logic [63:0]   mag_a, mag_b;
   logic [64:0]   trial;
   logic [63:0]   rem_sh;
   logic [79:0]   pp;
   logic [63:0]   cval;

   assign slt_ab = $signed(a) < $signed(b);
   assign slt_ba = $signed(b) < $signed(a);
   assign mag_a  = a[63] ? (64'd0 - a) : a;
   assign mag_b  = b[63] ? (64'd0 - b) : b;

   always_comb begin
      unique case (cast_bytes_code)
         cfpu_pkg::CAST_B1: cval = cast_to_unsigned ? {56'd0, a[7:0]}
                                                   : {{56{a[7]}}, a[7:0]};
         cfpu_pkg::CAST_B2: cval = cast_to_unsigned ? {48'd0, a[15:0]}
                                                   : {{48{a[15]}}, a[15:0]};
         cfpu_pkg::CAST_B4: cval = cast_to_unsigned ? {32'd0, a[31:0]}
                                                   : {{32{a[31]}}, a[31:0]};
         default:           cval = a;
      endcase
   end

   always_comb begin
      comb_r  = 64'd0;
      comb_ok = 1'b0;
      if (unary) begin
         unique case (ctl.op)
            cfpu_pkg::OP_NEG:    begin comb_r = 64'd0 - a; comb_ok = 1'b1; end
            cfpu_pkg::OP_NOT:    begin comb_r = ~a; comb_ok = 1'b1; end
            cfpu_pkg::OP_LOGNOT: begin comb_r = {63'd0, a == 64'd0}; comb_ok = 1'b1; end
            cfpu_pkg::OP_CAST:   begin comb_r = cval; comb_ok = !cast_to_float; end
            default: ;
         endcase
      end else begin
         unique case (ctl.op)
            cfpu_pkg::OP_ADD: begin comb_r = a + b; comb_ok = 1'b1; end
            cfpu_pkg::OP_SUB: begin comb_r = a - b; comb_ok = 1'b1; end
            cfpu_pkg::OP_AND: begin comb_r = a & b; comb_ok = 1'b1; end
            cfpu_pkg::OP_OR:  begin comb_r = a | b; comb_ok = 1'b1; end
            cfpu_pkg::OP_XOR: begin comb_r = a ^ b; comb_ok = 1'b1; end
            cfpu_pkg::OP_SHL: begin
               comb_r = a << b[5:0]; comb_ok = (b[63:6] == 58'd0);
            end
            cfpu_pkg::OP_SHR: begin
               comb_r = $unsigned($signed(a) >>> b[5:0]);
               comb_ok = (b[63:6] == 58'd0);
            end
            cfpu_pkg::OP_EQ: begin comb_r = {63'd0, a == b}; comb_ok = 1'b1; end
            cfpu_pkg::OP_NE: begin comb_r = {63'd0, a != b}; comb_ok = 1'b1; end
            cfpu_pkg::OP_LT: begin comb_r = {63'd0, slt_ab}; comb_ok = 1'b1; end
            cfpu_pkg::OP_LE: begin comb_r = {63'd0, !slt_ba}; comb_ok = 1'b1; end
            cfpu_pkg::OP_GT: begin comb_r = {63'd0, slt_ba}; comb_ok = 1'b1; end
            cfpu_pkg::OP_GE: begin comb_r = {63'd0, !slt_ab}; comb_ok = 1'b1; end
            default: ;
         endcase
      end
   end

   assign pp     = {16'd0, dvs_ff} * {64'd0, rem_ff[15:0]};
   assign rem_sh = {rem_ff[62:0], quo_ff[63]};
   assign trial  = {1'b0, rem_sh} - {1'b0, dvs_ff};

   always_comb begin
      st_in    = st_ff;
      acc_in   = acc_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      dvs_in   = dvs_ff;
      cnt_in   = cnt_ff;
      op_in    = op_ff;
      neg_q_in = neg_q_ff;
      neg_r_in = neg_r_ff;
      res_in   = res_ff;
      done_in  = 1'b0;
      ok_in    = ok_ff;
      unique case (st_ff)
         A_IDLE: begin
            if (ctl.start) begin
               op_in = ctl.op;
               if (!unary && ctl.op == cfpu_pkg::OP_MUL) begin
                  st_in  = A_MUL;
                  acc_in = 64'd0;
                  dvs_in = a;
                  rem_in = b;
                  cnt_in = 7'd0;
               end else if (!unary && (ctl.op == cfpu_pkg::OP_DIV ||
                                        ctl.op == cfpu_pkg::OP_MOD)) begin
                  if (b == 64'd0) begin
                     done_in = 1'b1;
                     ok_in   = 1'b0;
                     res_in  = 64'd0;
                  end else begin
                     st_in    = A_DIV;
                     quo_in   = mag_a;
                     dvs_in   = mag_b;
                     rem_in   = 64'd0;
                     cnt_in   = 7'd0;
                     neg_q_in = a[63] ^ b[63];
                     neg_r_in = a[63];
                  end
               end else begin
                  done_in = 1'b1;
                  ok_in   = comb_ok;
                  res_in  = comb_r;
               end
            end
         end
         A_MUL: begin
            // 16 bits of the multiplier per cycle
            acc_in = acc_ff + (pp[63:0] << {cnt_ff[1:0], 4'd0});
            rem_in = {16'd0, rem_ff[63:16]};
            cnt_in = cnt_ff + 7'd1;
            if (cnt_ff[1:0] == 2'd3) begin
               st_in   = A_IDLE;
               done_in = 1'b1;
               ok_in   = 1'b1;
               res_in  = acc_in;
            end
         end
         A_DIV: begin
            if (!trial[64]) begin
               rem_in = trial[63:0];
               quo_in = {quo_ff[62:0], 1'b1};
            end else begin
               rem_in = rem_sh;
               quo_in = {quo_ff[62:0], 1'b0};
            end
            cnt_in = cnt_ff + 7'd1;
            if (cnt_ff == 7'd63) st_in = A_FIX;
         end
         A_FIX: begin
            st_in   = A_IDLE;
            done_in = 1'b1;
            ok_in   = 1'b1;
            if (op_ff == cfpu_pkg::OP_DIV)
               res_in = neg_q_ff ? (64'd0 - quo_ff) : quo_ff;
            else
               res_in = neg_r_ff ? (64'd0 - rem_ff) : rem_ff;
         end
         default: st_in = A_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff   <= A_IDLE;
         done_ff <= 1'b0;
      end else begin
         st_ff   <= st_in;
         done_ff <= done_in;
      end
      acc_ff   <= acc_in;
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      dvs_ff   <= dvs_in;
      cnt_ff   <= cnt_in;
      op_ff    <= op_in;
      neg_q_ff <= neg_q_in;
      neg_r_ff <= neg_r_in;
      res_ff   <= res_in;
      ok_ff    <= ok_in;
   end

   assign sts.done = done_ff;
   assign sts.ok   = ok_ff;
   assign result   = res_ff;

endmodule
